// ===== src/lisp_token_scanner_assert.svh =====
// Assertion macros for the token scanner. Each use samples on clk and is
// disabled while rst_n is low.
`ifndef LISP_TOKEN_SCANNER_ASSERT_SVH
`define LISP_TOKEN_SCANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lts_pkg.sv =====
`default_nettype none

package lts_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_STRING  = 2'd2,
        MODE_SYMBOL  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_OK   = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    localparam int MAX_RESULTS = 4;

    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [7:0] DELIMS [8] = '{8'h5B, 8'h5D, 8'h28, 8'h29,
                                          8'h7B, 8'h7D, 8'h2E, 8'h27};

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  char_out;
        logic [15:0] token_count;
        logic        last;
    } result_t;

    // All results caused by one input byte, lowest slot first.
    typedef struct packed {
        logic [2:0]                    count;
        result_t [MAX_RESULTS-1:0]     slot;
    } burst_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D) || (c == 8'h00);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (c == DELIMS[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic result_t make_result(input kind_t k, input logic [7:0] ch,
                                            input logic [15:0] cnt);
        result_t r;
        r.kind        = k;
        r.char_out    = ch;
        r.token_count = cnt;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/lisp_token_scanner.sv =====
// Streaming Lisp token scanner.
// Source bytes arrive on the slave channel: s_tdata carries the byte and
// s_tlast marks the final byte of a buffer. Results leave on the master
// channel, one transfer each: a token byte, a token end, or, after the final
// byte, a done item whose tuser tells a clean end from an unmatched quote.
// m_tlast marks the last result caused by one source byte.
// A byte is held in an input register, decoded combinationally into its burst
// of zero to four results, and sent one result per cycle from the output
// buffer while the receiver is ready. The first result of a byte is valid
// once the byte moves from the input register into the output buffer, which
// waits for an earlier burst to drain. One byte per cycle is sustained while
// each byte yields at most one result and the receiver is ready; a byte with
// more holds the buffer until its last result is taken. A byte with no result
// never waits on the output side. While the receiver stalls, the current
// result holds and the input register fills, after which s_tready drops.
// Reset empties both registers and sets normal mode with a zero token count.
// The final byte of a buffer also returns the mode and count to that state.
`default_nettype none
`include "lisp_token_scanner_assert.svh"

module lisp_token_scanner #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // char_out[7:0], token_count[23:8]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);
    import lts_pkg::*;

    mode_t                 mode_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_char_reg;
    logic                  in_eot_reg;

    mode_t                 mode_next;
    logic [COUNT_BITS-1:0] count_next;
    burst_t                burst;
    logic                  can_load;
    logic                  consume;
    logic                  load;

    lts_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .mode_in     (mode_reg),
        .count_in    (count_reg),
        .char_in     (in_char_reg),
        .end_of_text (in_eot_reg),
        .mode_out    (mode_next),
        .count_out   (count_next),
        .burst       (burst)
    );

    lts_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_burst (burst),
        .can_load   (can_load),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // A byte with no results leaves the input register without the buffer.
    assign consume  = in_valid_reg && ((burst.count == 3'd0) || can_load);
    assign load     = in_valid_reg && (burst.count != 3'd0) && can_load;
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_NORMAL;
            count_reg    <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (consume) begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    `LTS_ASSERT_SAME(a_done_is_last,
        m_tvalid && (m_tuser == KIND_OK || m_tuser == KIND_ERR || m_tuser == KIND_END),
        m_tdata[7:0] == 8'h00 && (m_tuser == KIND_END || m_tlast),
        "done and token end items must carry no byte, and done must be last")
    `LTS_ASSERT_NEXT(a_fresh_after_end,
        consume && in_eot_reg,
        mode_reg == MODE_NORMAL && count_reg == '0,
        "scanner state must restart after the final byte of a buffer")

endmodule

`default_nettype wire

// ===== src/lts_decode.sv =====
`default_nettype none

module lts_decode #(
    parameter int COUNT_BITS = 16
) (
    input  lts_pkg::mode_t         mode_in,
    input  logic [COUNT_BITS-1:0]  count_in,
    input  logic [7:0]             char_in,
    input  logic                   end_of_text,
    output lts_pkg::mode_t         mode_out,
    output logic [COUNT_BITS-1:0]  count_out,
    output lts_pkg::burst_t        burst
);
    import lts_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    always_comb
    begin
        mode_t                 mode;
        logic [COUNT_BITS-1:0] cnt;
        logic [2:0]            n;
        logic                  do_normal;
        kind_t                 fin;
        burst_t                b;

        mode      = mode_in;
        cnt       = count_in;
        n         = 3'd0;
        do_normal = 1'b0;
        fin       = KIND_OK;
        b         = '0;

        unique case (mode)
            MODE_COMMENT:
            begin
                if (char_in == CHAR_LF) begin
                    mode = MODE_NORMAL;
                end
            end
            MODE_STRING:
            begin
                b.slot[n[1:0]] = make_result(KIND_BYTE, char_in, 16'(cnt));
                n = n + 3'd1;
                if (char_in == CHAR_QUOTE) begin
                    cnt = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_ONE;
                    b.slot[n[1:0]] = make_result(KIND_END, 8'h00, 16'(cnt));
                    n = n + 3'd1;
                    mode = MODE_NORMAL;
                end
            end
            MODE_SYMBOL:
            begin
                if (is_blank(char_in) || is_delim(char_in) ||
                    char_in == CHAR_SEMI || char_in == CHAR_QUOTE) begin
                    cnt = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_ONE;
                    b.slot[n[1:0]] = make_result(KIND_END, 8'h00, 16'(cnt));
                    n = n + 3'd1;
                    mode = MODE_NORMAL;
                    do_normal = 1'b1;
                end else begin
                    b.slot[n[1:0]] = make_result(KIND_BYTE, char_in, 16'(cnt));
                    n = n + 3'd1;
                end
            end
            default:
            begin
                do_normal = 1'b1;
            end
        endcase

        // A byte in normal mode, or one that closes a symbol, is handled here as in normal mode.
        if (do_normal && !is_blank(char_in)) begin
            if (char_in == CHAR_SEMI) begin
                mode = MODE_COMMENT;
            end else if (is_delim(char_in)) begin
                b.slot[n[1:0]] = make_result(KIND_BYTE, char_in, 16'(cnt));
                n = n + 3'd1;
                cnt = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_ONE;
                b.slot[n[1:0]] = make_result(KIND_END, 8'h00, 16'(cnt));
                n = n + 3'd1;
            end else if (char_in == CHAR_QUOTE) begin
                b.slot[n[1:0]] = make_result(KIND_BYTE, char_in, 16'(cnt));
                n = n + 3'd1;
                mode = MODE_STRING;
            end else begin
                b.slot[n[1:0]] = make_result(KIND_BYTE, char_in, 16'(cnt));
                n = n + 3'd1;
                mode = MODE_SYMBOL;
            end
        end

        if (end_of_text) begin
            if (mode == MODE_SYMBOL) begin
                cnt = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_ONE;
                b.slot[n[1:0]] = make_result(KIND_END, 8'h00, 16'(cnt));
                n = n + 3'd1;
            end else if (mode == MODE_STRING) begin
                fin = KIND_ERR;
            end
            b.slot[n[1:0]] = make_result(fin, 8'h00, 16'(cnt));
            n = n + 3'd1;
            mode = MODE_NORMAL;
            cnt = '0;
        end

        if (n != 3'd0) begin
            b.slot[2'(n - 3'd1)].last = 1'b1;
        end
        b.count = n;

        mode_out  = mode;
        count_out = cnt;
        burst     = b;
    end

endmodule

`default_nettype wire

// ===== src/lts_burst.sv =====
`default_nettype none

module lts_burst (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  lts_pkg::burst_t load_burst,
    output logic            can_load,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [23:0]     m_tdata,   // char_out[7:0], token_count[23:8]
    output logic [1:0]      m_tuser,   // kind[1:0]
    output logic            m_tlast
);
    import lts_pkg::*;

    burst_t     burst_reg;
    logic [1:0] idx_reg;
    logic       busy_reg;
    result_t    cur;
    logic       fire;
    logic       final_slot;

    assign cur        = burst_reg.slot[idx_reg];
    assign fire       = busy_reg && m_tready;
    assign final_slot = ({1'b0, idx_reg} + 3'd1) == burst_reg.count;
    assign can_load   = !busy_reg || (fire && final_slot);

    assign m_tvalid = busy_reg;
    assign m_tdata  = {cur.token_count, cur.char_out};
    assign m_tuser  = cur.kind;
    assign m_tlast  = cur.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end else if (fire && final_slot) begin
            busy_reg <= 1'b0;
        end else if (fire) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            burst_reg <= load_burst;
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_lisp_token_scanner.sv =====
`default_nettype none

module tb_lisp_token_scanner;
    import lts_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;
    localparam result_t NO_RES = '0;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } src_byte_t;

    // n_fixed < 0 means the row is checked against the scanner model below.
    typedef struct packed {
        src_byte_t      b;
        int             n_fixed;
        result_t [3:0]  fixed;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // char_in[7:0]
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;             // char_out[7:0], token_count[23:8]
    logic [1:0]  m_tuser;             // kind[1:0]
    logic        m_tlast;

    lisp_token_scanner dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mode_t       lex_mode = MODE_NORMAL;
    logic [15:0] tok_cnt = '0;
    result_t     step_results[$];
    result_t     results_due[$];
    row_t        directed[$];
    src_byte_t   random_text[$];

    int burst_left = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int rx_tick = 0;
    int rx_style = 0;
    int rx_hold = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Scanner model
    // ---------------------------------------------------------------
    function automatic result_t res(kind_t k, logic [7:0] ch, logic [15:0] cnt, logic lst);
        result_t r;
        r.kind        = k;
        r.char_out    = ch;
        r.token_count = cnt;
        r.last        = lst;
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D) || (c == 8'h00);
    endfunction

    function automatic logic is_punct(logic [7:0] c);
        case (c)
            "[", "]", "(", ")", "{", "}", ".", "'": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void emit(kind_t k, logic [7:0] ch);
        if (step_results.size() < MAX_RESULTS)
        begin
            step_results.push_back(res(k, ch, tok_cnt, 1'b0));
        end
    endfunction

    function automatic void close_token();
        if (tok_cnt != COUNT_TOP)
        begin
            tok_cnt = tok_cnt + 16'd1;
        end
        emit(KIND_END, 8'h00);
    endfunction

    function automatic void lex_plain(logic [7:0] c);
        if (is_space(c))
        begin
            // separators produce nothing outside a token
        end
        else if (c == CHAR_SEMI)
        begin
            lex_mode = MODE_COMMENT;
        end
        else if (is_punct(c))
        begin
            emit(KIND_BYTE, c);
            close_token();
        end
        else if (c == CHAR_QUOTE)
        begin
            emit(KIND_BYTE, c);
            lex_mode = MODE_STRING;
        end
        else
        begin
            emit(KIND_BYTE, c);
            lex_mode = MODE_SYMBOL;
        end
    endfunction

    function automatic void lex_step(logic [7:0] c, logic eot);
        kind_t final_kind;
        step_results.delete();
        case (lex_mode)
            MODE_COMMENT:
            begin
                if (c == CHAR_LF)
                begin
                    lex_mode = MODE_NORMAL;
                end
            end
            MODE_STRING:
            begin
                emit(KIND_BYTE, c);
                if (c == CHAR_QUOTE)
                begin
                    close_token();
                    lex_mode = MODE_NORMAL;
                end
            end
            MODE_SYMBOL:
            begin
                if (is_space(c) || is_punct(c) || c == CHAR_SEMI || c == CHAR_QUOTE)
                begin
                    close_token();
                    lex_mode = MODE_NORMAL;
                    lex_plain(c);
                end
                else
                begin
                    emit(KIND_BYTE, c);
                end
            end
            default: lex_plain(c);
        endcase
        if (eot)
        begin
            final_kind = KIND_OK;
            if (lex_mode == MODE_SYMBOL)
            begin
                close_token();
            end
            else if (lex_mode == MODE_STRING)
            begin
                final_kind = KIND_ERR;
            end
            emit(final_kind, 8'h00);
            lex_mode = MODE_NORMAL;
            tok_cnt  = '0;
        end
        if (step_results.size() > 0)
        begin
            step_results[step_results.size()-1].last = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus construction
    // ---------------------------------------------------------------
    function automatic void add_row(logic [7:0] ch, logic eot);
        row_t r;
        r.b       = '{ch, eot};
        r.n_fixed = -1;
        r.fixed   = '0;
        directed.push_back(r);
    endfunction

    function automatic void add_fixed(logic [7:0] ch, logic eot, int n,
                                      result_t r0, result_t r1, result_t r2, result_t r3);
        row_t r;
        r.b        = '{ch, eot};
        r.n_fixed  = n;
        r.fixed[0] = r0;
        r.fixed[1] = r1;
        r.fixed[2] = r2;
        r.fixed[3] = r3;
        directed.push_back(r);
    endfunction

    function automatic void put_text(logic [7:0] c);
        random_text.push_back('{c, 1'b0});
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 7))
            0: return "[";
            1: return "]";
            2: return "(";
            3: return ")";
            4: return "{";
            5: return "}";
            6: return ".";
            default: return "'";
        endcase
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 6))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            3: return 8'h0B;
            4: return 8'h0C;
            5: return 8'h0D;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] pick_sym_byte();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (is_space(c) || is_punct(c) || c == CHAR_SEMI || c == CHAR_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] pick_other_than(logic [7:0] banned);
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == banned);
        return c;
    endfunction

    // One source buffer: mostly well-formed text ending on end_of_text, sometimes
    // raw noise that may or may not close the buffer.
    function automatic void gen_buffer();
        int n_tok;
        int len;
        if ($urandom_range(0, 4) == 0)
        begin
            len = $urandom_range(3, 10);
            for (int i = 0; i < len; i++)
            begin
                random_text.push_back('{8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0});
            end
        end
        else
        begin
            n_tok = $urandom_range(1, 8);
            for (int t = 0; t < n_tok; t++)
            begin
                case ($urandom_range(0, 8))
                    0, 1, 2:
                    begin
                        len = $urandom_range(1, 5);
                        for (int i = 0; i < len; i++)
                        begin
                            put_text(pick_sym_byte());
                        end
                    end
                    3, 4: put_text(pick_punct());
                    5:
                    begin
                        put_text(CHAR_QUOTE);
                        len = $urandom_range(0, 5);
                        for (int i = 0; i < len; i++)
                        begin
                            put_text(pick_other_than(CHAR_QUOTE));
                        end
                        put_text(CHAR_QUOTE);
                    end
                    6:
                    begin
                        put_text(CHAR_SEMI);
                        len = $urandom_range(0, 4);
                        for (int i = 0; i < len; i++)
                        begin
                            put_text(pick_other_than(CHAR_LF));
                        end
                        put_text(CHAR_LF);
                    end
                    default:
                    begin
                        len = $urandom_range(1, 2);
                        for (int i = 0; i < len; i++)
                        begin
                            put_text(pick_space());
                        end
                    end
                endcase
            end
            // Occasionally leave a string or a comment open at the end.
            case ($urandom_range(0, 7))
                0:
                begin
                    put_text(CHAR_QUOTE);
                    len = $urandom_range(0, 3);
                    for (int i = 0; i < len; i++)
                    begin
                        put_text(pick_other_than(CHAR_QUOTE));
                    end
                end
                1: put_text(CHAR_SEMI);
                default: ;
            endcase
            random_text[random_text.size()-1].eot = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------
    // Source side
    // ---------------------------------------------------------------
    task automatic send_row(input row_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.b.ch;
        s_tlast  <= r.b.eot;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        lex_step(r.b.ch, r.b.eot);
        if (r.n_fixed < 0)
        begin
            foreach (step_results[k])
            begin
                results_due.push_back(step_results[k]);
            end
        end
        else
        begin
            for (int k = 0; k < r.n_fixed; k++)
            begin
                results_due.push_back(r.fixed[k]);
            end
        end
        burst_left--;
        bytes_sent++;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Result side: the receiver switches between several stall styles.
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 50 == 0)
        begin
            rx_style <= $urandom_range(0, 3);
        end
        case (rx_style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2:
            begin
                if (rx_hold > 0)
                begin
                    rx_hold  <= rx_hold - 1;
                    m_tready <= 1'b0;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    rx_hold  <= $urandom_range(1, 7);
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
            default: m_tready <= (rx_tick % 4 != 3);
        endcase
    end

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind        = kind_t'(m_tuser);
            got.char_out    = m_tdata[7:0];
            got.token_count = m_tdata[23:8];
            got.last        = m_tlast;
            results_seen++;
            if (results_due.size() == 0)
            begin
                flag_error($sformatf("unexpected result: kind %0d char %h count %0d last %b",
                                     got.kind, got.char_out, got.token_count, got.last));
            end
            else
            begin
                want = results_due.pop_front();
                if (got !== want)
                begin
                    flag_error($sformatf({"result %0d: expected kind %0d char %h count %0d ",
                                          "last %b, got kind %0d char %h count %0d last %b"},
                                         results_seen, want.kind, want.char_out,
                                         want.token_count, want.last, got.kind, got.char_out,
                                         got.token_count, got.last));
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either side.
    always @(posedge clk)
    begin
        if (rst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
        begin
            idle_cycles <= idle_cycles + 1;
        end
        else
        begin
            idle_cycles <= 0;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
                     $realtime, STALL_LIMIT, results_due.size());
            $display("tb_lisp_token_scanner: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        row_t r;
        int n_directed;
        int n_random;

        // Directed text. Expected results are written out where obvious.
        add_fixed("(", 1'b0, 2, res(KIND_BYTE, "(", 16'd0, 1'b0),
                  res(KIND_END, 8'h00, 16'd1, 1'b1), NO_RES, NO_RES);
        add_row("a", 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(8'h20, 1'b0);
        add_fixed(8'h00, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(CHAR_QUOTE, 1'b0);
        add_row(CHAR_SEMI, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(CHAR_QUOTE, 1'b0);
        add_row(CHAR_SEMI, 1'b0);
        add_row("x", 1'b0);
        add_row(CHAR_LF, 1'b0);
        add_row("b", 1'b0);
        add_row(CHAR_QUOTE, 1'b0);
        add_row("q", 1'b0);
        // End of text inside a string reports the unmatched quote.
        add_fixed("z", 1'b1, 2, res(KIND_BYTE, "z", 16'd4, 1'b0),
                  res(KIND_ERR, 8'h00, 16'd4, 1'b1), NO_RES, NO_RES);
        add_fixed("s", 1'b1, 3, res(KIND_BYTE, "s", 16'd0, 1'b0),
                  res(KIND_END, 8'h00, 16'd1, 1'b0), res(KIND_OK, 8'h00, 16'd1, 1'b1), NO_RES);
        add_fixed(CHAR_SEMI, 1'b1, 1, res(KIND_OK, 8'h00, 16'd0, 1'b1),
                  NO_RES, NO_RES, NO_RES);
        add_row("t", 1'b0);
        add_row(")", 1'b0);
        add_row("u", 1'b0);
        add_row(CHAR_QUOTE, 1'b1);
        add_row("v", 1'b0);
        add_row(CHAR_SEMI, 1'b1);
        add_row("w", 1'b0);
        add_row(".", 1'b1);
        add_fixed(8'h0D, 1'b1, 1, res(KIND_OK, 8'h00, 16'd0, 1'b1),
                  NO_RES, NO_RES, NO_RES);

        while (random_text.size() < 235)
        begin
            gen_buffer();
        end
        n_directed = directed.size();
        n_random   = random_text.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            send_row(directed[i]);
        end

        foreach (random_text[i])
        begin
            r.b       = random_text[i];
            r.n_fixed = -1;
            r.fixed   = '0;
            send_row(r);
        end

        s_tvalid <= 1'b0;
        while (results_due.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("tb_lisp_token_scanner: %0d bytes sent: %0d directed, %0d random text,",
                 bytes_sent, n_directed, n_random);
        $display("  under bursty sending and receiver stalls; %0d results checked, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0 && results_due.size() == 0)
        begin
            $display("tb_lisp_token_scanner: done, clean");
        end
        else
        begin
            $display("tb_lisp_token_scanner: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== lisp_token_scanner.f =====
+incdir+src
src/lts_pkg.sv
src/lts_decode.sv
src/lts_burst.sv
src/lisp_token_scanner.sv
sim/tb_lisp_token_scanner.sv
